@@ hw/rtl/bdo_pkg.sv @@
package bdo_pkg;

	localparam int IMG_W = 512;
	localparam int IMG_H = 512;
	localparam int COL_W = $clog2(IMG_W);
	// rows count up to IMG_H + 2 while the frame is flushed
	localparam int ROW_W = $clog2(IMG_H + 3);
	localparam int WIN = 5;
	localparam int HIST = WIN - 1;
	localparam int POS_W = 9;

	localparam logic [7:0] THRESH_RST = 8'd127;
	localparam logic [7:0] LEVEL_FG = 8'd255;
	localparam logic [7:0] LEVEL_BG = 8'd0;

	// bit (dr+2)*5 + (dc+2): octagon with 3, 5, 5, 5, 3 columns per row
	localparam logic [WIN*WIN-1:0] KERNEL = 25'h0EFFFEE;

	typedef enum logic {
		REG_THRESHOLD = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic fg;
		logic emit;
		logic last;
		logic [COL_W-1:0] col;
		logic [WIN-1:0] row_ok;
		logic [WIN-1:0] col_ok;
		logic [POS_W-1:0] row_o;
		logic [POS_W-1:0] col_o;
	} stage_t;

endpackage

@@ hw/rtl/bdo_ram.sv @@
module bdo_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 512
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/bdo_scan.sv @@
module bdo_scan (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] threshold,
	input  logic s_valid,
	input  logic [7:0] gray_level,
	input  logic pad,
	output logic s_ready,
	input  logic s1_go,
	output logic rd_en,
	output logic [bdo_pkg::COL_W-1:0] rd_addr,
	output logic s1_valid,
	output bdo_pkg::stage_t s1
);

	import bdo_pkg::*;

	localparam logic [ROW_W-1:0] ROW_TWO = ROW_W'(2);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMG_H - 1);
	localparam logic [ROW_W-1:0] ROW_END = ROW_W'(IMG_H);
	localparam logic [COL_W-1:0] COL_TWO = COL_W'(2);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMG_W - 1);

	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [COL_W-1:0] in_col_q, out_col_q;
	logic s1_valid_q;
	stage_t s1_q;
	stage_t stage;
	logic in_frame, counted, emit, last;
	logic [ROW_W+1:0] row_sum;
	logic [COL_W+1:0] col_sum;

	assign in_frame = in_row_q < ROW_END;
	assign s_ready = !s1_valid_q || s1_go;
	// pads inside the frame are dropped without a trace
	assign counted = s_valid && s_ready && !(in_frame && pad);
	assign emit = (in_row_q > ROW_TWO) || (in_row_q == ROW_TWO && in_col_q >= COL_TWO);
	assign last = (out_row_q == ROW_LAST) && (out_col_q == COL_LAST);

	assign row_sum = (ROW_W+2)'(out_row_q) + (ROW_W+2)'(2);
	assign col_sum = (COL_W+2)'(out_col_q) + (COL_W+2)'(2);

	always_comb begin
		stage.fg = in_frame && (gray_level > threshold);
		stage.emit = emit;
		stage.last = last;
		stage.col = in_col_q;
		stage.row_o = POS_W'(out_row_q);
		stage.col_o = POS_W'(out_col_q);
		for (int k = 0; k < WIN; k++) begin
			stage.row_ok[k] = (row_sum >= (ROW_W+2)'(k)) &&
				((row_sum - (ROW_W+2)'(k)) < (ROW_W+2)'(IMG_H));
			stage.col_ok[k] = (col_sum >= (COL_W+2)'(k)) &&
				((col_sum - (COL_W+2)'(k)) < (COL_W+2)'(IMG_W));
		end
	end

	assign rd_en = counted;
	assign rd_addr = in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (counted) begin
			if (emit && last) begin
				in_row_q <= '0;
				in_col_q <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				if (in_col_q == COL_LAST) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (emit) begin
					if (out_col_q == COL_LAST) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (counted) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (counted) begin
			s1_q <= stage;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1 = s1_q;

endmodule

@@ hw/rtl/bdo_win.sv @@
module bdo_win (
	input  logic clk,
	input  logic arst_n,
	input  logic s1_valid,
	input  bdo_pkg::stage_t s1,
	input  logic [bdo_pkg::HIST-1:0] rd_data,
	output logic s1_go,
	output logic we,
	output logic [bdo_pkg::COL_W-1:0] waddr,
	output logic [bdo_pkg::HIST-1:0] wdata,
	input  logic out_ready,
	output logic out_valid,
	output logic [7:0] out_level,
	output logic [bdo_pkg::POS_W-1:0] out_row,
	output logic [bdo_pkg::POS_W-1:0] out_col,
	output logic out_last
);

	import bdo_pkg::*;

	logic [WIN-1:0] vec;
	logic [WIN-1:0][WIN-1:0] win_q, win_next;
	logic hit, out_free;
	logic out_valid_q, out_last_q;
	logic [7:0] out_level_q;
	logic [POS_W-1:0] out_row_q, out_col_q;

	assign out_free = !out_valid_q || out_ready;
	assign s1_go = s1_valid && (!s1.emit || out_free);

	// bit k of a column is the row k above the newest one
	assign vec = {rd_data, s1.fg};

	assign we = s1_go;
	assign waddr = s1.col;
	assign wdata = {rd_data[HIST-2:0], s1.fg};

	always_comb begin
		win_next[0] = vec;
		for (int i = 1; i < WIN; i++) begin
			win_next[i] = win_q[i-1];
		end
		hit = 1'b0;
		for (int i = 0; i < WIN; i++) begin
			for (int k = 0; k < WIN; k++) begin
				hit = hit | (KERNEL[(WIN-1-k)*WIN + (WIN-1-i)] & s1.row_ok[k] &
					s1.col_ok[i] & win_next[i][k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			win_q <= win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1.emit) begin
			out_level_q <= hit ? LEVEL_FG : LEVEL_BG;
			out_row_q <= s1.row_o;
			out_col_q <= s1.col_o;
			out_last_q <= s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_level = out_level_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign out_last = out_last_q;

endmodule

@@ hw/rtl/binary_dilation_octagon_5x5.sv @@
// The item that completes a pixel's 5x5 neighborhood (two rows and two columns
// later in the raster) passes the front-end register, then the output register.
// Throughput: one item per cycle unless the output blocks; the line memory is
// read on accept and written back at another column, so no interlock is needed.
// Reset: position counters, valid flags and threshold (127) clear at once;
// the line memory keeps no reset, stale rows are masked at the image borders.
module binary_dilation_octagon_5x5 (
	input  logic clk,
	input  logic arst_n,
	// configuration port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// pixel input
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [7:0] gray_level
	input  logic [0:0] s_tuser,   // [0] pad
	// dilated output
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata,  // [7:0] out_level, [16:8] row, [25:17] column
	output logic m_tlast          // frame_end
);

	import bdo_pkg::*;

	logic [7:0] threshold_q;
	logic cfg_wr;
	logic rd_en, we, s1_valid, s1_go;
	logic [COL_W-1:0] rd_addr, waddr;
	logic [HIST-1:0] rd_data, wdata;
	stage_t s1;
	logic [7:0] out_level;
	logic [POS_W-1:0] out_row, out_col;

	// Registers: threshold only, written on the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RST;
		end else if (cfg_wr && (reg_idx_t'(paddr[2]) == REG_THRESHOLD)) begin
			threshold_q <= pwdata[7:0];
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_THRESHOLD: prdata = {24'b0, threshold_q};
			default: prdata = '0;
		endcase
	end

	// Front end: count raster positions, threshold the pixel, issue the
	// line memory read for its column.
	bdo_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.threshold(threshold_q),
		.s_valid(s_tvalid),
		.gray_level(s_tdata),
		.pad(s_tuser[0]),
		.s_ready(s_tready),
		.s1_go(s1_go),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.s1_valid(s1_valid),
		.s1(s1)
	);

	// Line memory: the four rows above the current one, one column per entry.
	bdo_ram #(
		.WIDTH(HIST),
		.DEPTH(IMG_W)
	) u_line_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Back end: shift the column into the window, write the aged column back,
	// OR the kernel taps and hold the result in the output register.
	bdo_win u_win (
		.clk(clk),
		.arst_n(arst_n),
		.s1_valid(s1_valid),
		.s1(s1),
		.rd_data(rd_data),
		.s1_go(s1_go),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_level(out_level),
		.out_row(out_row),
		.out_col(out_col),
		.out_last(m_tlast)
	);

	assign m_tdata = {6'b0, out_col, out_row, out_level};

	// A stalled stage must not issue a read: its column data would be lost.
	a_hold_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_go |=> $stable(rd_data))
		else $error("line memory data changed under a stalled stage");

	// Input stalls only when the output register is full and blocked.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

	// Frame end marks the bottom right pixel only.
	a_frame_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |->
		(m_tdata[16:8] == POS_W'(IMG_H - 1)) && (m_tdata[25:17] == POS_W'(IMG_W - 1)))
		else $error("frame end on wrong position");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import bdo_pkg::*;

	// one pixel item as it goes onto the input bus
	typedef struct packed {
		logic pad;
		logic [7:0] gray;
	} pix_item_t;

	// one dilated pixel as it should leave the block
	typedef struct packed {
		logic [7:0] level;
		logic [8:0] row;
		logic [8:0] column;
		logic frame_end;
	} dil_res_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;   // [7:0] gray_level
	logic [0:0] s_tuser;   // [0] pad
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;  // [7:0] out_level, [16:8] row, [25:17] column
	logic m_tlast;         // frame_end

	binary_dilation_octagon_5x5 i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// predictor state: binary rows of the image, raster counters, threshold
	logic fg_rows [WIN][IMG_W];
	int unsigned pix_row, pix_col;
	int unsigned res_row, res_col;
	logic [7:0] cur_thresh;

	dil_res_t dilated_q [$];
	int mismatch_cnt;

	// idle rates in percent and the long receiver hold-off
	int tx_idle_pct;
	int rx_idle_pct;
	int stall_req;
	int stall_left;

	// directed items at the head of the first frame
	pix_item_t dir_rows [0:17] = '{
		{1'b1, 8'hFF},  // pad before the first pixel: ignored
		{1'b1, 8'h00},
		{1'b0, 8'h00},  // darkest pixel
		{1'b0, 8'hFF},  // brightest pixel
		{1'b0, 8'd127}, // equal to the threshold: background
		{1'b0, 8'd128}, // one above the threshold: foreground
		{1'b1, 8'hFF},  // pad inside the frame: ignored
		{1'b0, 8'hAA},
		{1'b0, 8'h55},
		{1'b0, 8'd126},
		{1'b1, 8'h80},
		{1'b0, 8'h01},
		{1'b0, 8'hFE},
		{1'b0, 8'h7F},
		{1'b0, 8'h80},
		{1'b1, 8'h00},
		{1'b0, 8'h00},
		{1'b0, 8'hFF}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop: the whole run needs well under 0.1 ms
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Predict the block for one accepted item: store the thresholded bit,
	// then, once two rows and two columns are in, OR the octagon around the
	// output position, skipping neighbors outside the image.
	task automatic dilate_pixel(input logic [7:0] gray, input logic pad);
		bit in_frame;
		bit emit;
		bit hit;
		int dr, dc, rr, cc;
		dil_res_t r;
		in_frame = pix_row < IMG_H;
		// pad inside the frame changes nothing
		if (in_frame && pad)
			return;
		if (in_frame)
			fg_rows[pix_row % WIN][pix_col] = gray > cur_thresh;
		emit = pix_row > 2 || (pix_row == 2 && pix_col >= 2);
		pix_col++;
		if (pix_col >= IMG_W) begin
			pix_col = 0;
			pix_row++;
		end
		if (!emit)
			return;
		hit = 1'b0;
		for (dr = -2; dr <= 2; dr++) begin
			rr = int'(res_row) + dr;
			if (rr < 0 || rr >= IMG_H)
				continue;
			for (dc = -2; dc <= 2; dc++) begin
				cc = int'(res_col) + dc;
				if (cc < 0 || cc >= IMG_W)
					continue;
				// the four corners of the 5x5 square are not in the octagon
				if ((dr == 2 || dr == -2) && (dc == 2 || dc == -2))
					continue;
				if (fg_rows[rr % WIN][cc])
					hit = 1'b1;
			end
		end
		r.level = hit ? LEVEL_FG : LEVEL_BG;
		r.row = res_row[8:0];
		r.column = res_col[8:0];
		r.frame_end = res_row == IMG_H - 1 && res_col == IMG_W - 1;
		dilated_q.push_back(r);
		if (r.frame_end) begin
			// end of frame: every counter starts over
			pix_row = 0;
			pix_col = 0;
			res_row = 0;
			res_col = 0;
		end else begin
			res_col++;
			if (res_col >= IMG_W) begin
				res_col = 0;
				res_row++;
			end
		end
	endtask

	// Offer one item, idling first at the current rate, and hold it until
	// the block takes it; then advance the predictor.
	task automatic push_pixel(input logic [7:0] gray, input logic pad);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= gray;
		s_tuser <= pad;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		dilate_pixel(gray, pad);
	endtask

	// Drop valid, let every expected pixel arrive, then let the pipeline run on
	// idle, since items near the frame start emit nothing.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (dilated_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_THRESHOLD)
			cur_thresh = val[7:0];
	endtask

	// read the threshold back and compare with what the predictor holds
	task automatic check_thresh;
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_THRESHOLD, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got[7:0] != cur_thresh) begin
			$error("threshold: expected %0d, got %0d", cur_thresh, got[7:0]);
			mismatch_cnt++;
		end
	endtask

	// Gray level with roughly fg_pct percent of pixels above the threshold,
	// so the dilated image is neither all white nor all black.
	function automatic logic [7:0] pick_gray(input int fg_pct);
		if ($urandom_range(99) < fg_pct && cur_thresh != 8'hFF)
			return 8'($urandom_range(255, int'(cur_thresh) + 1));
		return 8'($urandom_range(int'(cur_thresh), 0));
	endfunction

	// Receiver: check each accepted pixel against the oldest expectation,
	// then pick tready for the next cycle. A hold-off request keeps tready
	// low for a long stretch so the block backs up into its input.
	always @(posedge clk) begin : rx_side
		dil_res_t want;
		if (m_tvalid && m_tready) begin
			if (dilated_q.size() == 0) begin
				$error("unexpected pixel: level %0d row %0d column %0d",
					m_tdata[7:0], m_tdata[16:8], m_tdata[25:17]);
				mismatch_cnt++;
			end else begin
				want = dilated_q.pop_front();
				if (m_tdata[7:0] != want.level) begin
					$error("out_level: expected %0d, got %0d", want.level, m_tdata[7:0]);
					mismatch_cnt++;
				end
				if (m_tdata[16:8] != want.row) begin
					$error("row: expected %0d, got %0d", want.row, m_tdata[16:8]);
					mismatch_cnt++;
				end
				if (m_tdata[25:17] != want.column) begin
					$error("column: expected %0d, got %0d", want.column, m_tdata[25:17]);
					mismatch_cnt++;
				end
				if (m_tlast != want.frame_end) begin
					$error("frame_end: expected %0d, got %0d", want.frame_end, m_tlast);
					mismatch_cnt++;
				end
			end
		end
		if (stall_req > 0 && stall_left == 0) begin
			stall_left = stall_req;
			stall_req = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= rx_idle_pct;
		end
	end

	initial begin
		int n;
		int dens;
		logic [7:0] gray;
		logic pad;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		tx_idle_pct = 14;
		rx_idle_pct = 74;
		stall_req = 0;
		stall_left = 0;
		mismatch_cnt = 0;
		fg_rows = '{default: '0};
		pix_row = 0;
		pix_col = 0;
		res_row = 0;
		res_col = 0;
		cur_thresh = THRESH_RST;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// threshold comes out of reset at 127
		check_thresh();

		// Phase 1: sparse sender gaps, receiver mostly stalled, reset threshold.
		// Directed head of the frame first, then random pixels with some pads.
		for (n = 0; n < $size(dir_rows); n++)
			push_pixel(dir_rows[n].gray, dir_rows[n].pad);
		dens = 5;
		for (n = 0; n < 1100; n++) begin
			if (n % 256 == 0)
				dens = $urandom_range(12, 1);
			pad = $urandom_range(99) < 4;
			push_pixel(pick_gray(dens), pad);
		end
		drain();

		// Phase 2: swap the idle rates; threshold at its low extreme, where
		// only a zero gray level is background.
		tx_idle_pct = 74;
		rx_idle_pct = 14;
		reg_write(REG_THRESHOLD, 32'd0);
		check_thresh();
		for (n = 0; n < 180; n++) begin
			pad = $urandom_range(99) < 4;
			gray = $urandom_range(99) < 85 ? 8'h00 : 8'($urandom_range(255, 1));
			push_pixel(gray, pad);
		end
		drain();

		// Phase 3: no idling. Start at the high extreme (nothing foreground)
		// and hold the receiver off for a long stretch while items keep
		// coming, then go on at a random threshold set at an idle point.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		reg_write(REG_THRESHOLD, 32'd255);
		check_thresh();
		stall_req = 400;
		for (n = 0; n < 80; n++) begin
			pad = $urandom_range(99) < 2;
			push_pixel(pick_gray(dens), pad);
		end
		drain();

		reg_write(REG_THRESHOLD, 32'($urandom_range(254, 1)));
		check_thresh();
		dens = $urandom_range(12, 1);
		for (n = 0; n < 70; n++) begin
			pad = $urandom_range(99) < 2;
			push_pixel(pick_gray(dens), pad);
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
